FILE: src/bwi_pkg.sv
// Shared types, colors and codes for the blindspot warning indicator.
package bwi_pkg;

  localparam int unsigned CFG_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned COLOR_BITS = 24;
  localparam int unsigned CODE_BITS = 3;
  localparam int unsigned STAGE_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_BLINK = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_BLINK = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINK_TIMEOUT = 2'd2;

  localparam logic [CFG_BITS-1:0] FAST_BLINK_RESET = 16'd500;
  localparam logic [CFG_BITS-1:0] SLOW_BLINK_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] LINK_TIMEOUT_RESET = 16'd5000;

  localparam logic [COLOR_BITS-1:0] COLOR_OFF = 24'h000000;
  localparam logic [COLOR_BITS-1:0] COLOR_GREEN = 24'h00FF00;
  localparam logic [COLOR_BITS-1:0] COLOR_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_BITS-1:0] COLOR_RED = 24'hFF0000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MESSAGE = 1'b1;

  localparam logic [CODE_BITS-1:0] SPD_OFF = 3'd0;
  localparam logic [CODE_BITS-1:0] SPD_YELLOW = 3'd1;
  localparam logic [CODE_BITS-1:0] SPD_YELLOW_SLOW = 3'd2;
  localparam logic [CODE_BITS-1:0] SPD_YELLOW_FAST = 3'd3;
  localparam logic [CODE_BITS-1:0] SPD_RED = 3'd4;
  localparam logic [CODE_BITS-1:0] SPD_RED_SLOW = 3'd5;
  localparam logic [CODE_BITS-1:0] SPD_RED_FAST = 3'd6;
  localparam logic [CODE_BITS-1:0] SPD_RED_ALARM = 3'd7;

  localparam logic [CODE_BITS-1:0] REAR_FAR = 3'd0;
  localparam logic [CODE_BITS-1:0] REAR_MID = 3'd1;
  localparam logic [CODE_BITS-1:0] REAR_NEAR = 3'd2;
  localparam logic [CODE_BITS-1:0] REAR_YELLOW_SLOW = 3'd3;
  localparam logic [CODE_BITS-1:0] REAR_YELLOW = 3'd4;
  localparam logic [CODE_BITS-1:0] REAR_YELLOW_FAST = 3'd5;
  localparam logic [CODE_BITS-1:0] REAR_RED_FAST = 3'd6;
  localparam logic [CODE_BITS-1:0] REAR_NONE = 3'd7;

  localparam logic [STAGE_BITS-1:0] STAGE_SILENT = 3'd0;
  localparam logic [STAGE_BITS-1:0] STAGE_1 = 3'd1;
  localparam logic [STAGE_BITS-1:0] STAGE_2 = 3'd2;
  localparam logic [STAGE_BITS-1:0] STAGE_3 = 3'd3;
  localparam logic [STAGE_BITS-1:0] STAGE_4 = 3'd4;

  typedef struct packed {
    logic                 right_present;
    logic                 left_present;
    logic [CODE_BITS-1:0] rear_code;
    logic [CODE_BITS-1:0] speed_code;
  } item_t;

  typedef struct packed {
    logic                  link_lost;
    logic [STAGE_BITS-1:0] sound_stage;
    logic                  sound_valid;
    logic [COLOR_BITS-1:0] right_color;
    logic [COLOR_BITS-1:0] rear_color;
    logic [COLOR_BITS-1:0] speed_color;
    logic [COLOR_BITS-1:0] left_color;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] fast_blink_ms;
    logic [CFG_BITS-1:0] slow_blink_ms;
    logic [CFG_BITS-1:0] link_timeout_ms;
  } cfg_t;

endpackage

FILE: src/bwi_blink.sv
// Blink interval check: fires when the half period has elapsed since the last toggle.
module bwi_blink #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]         now_ms,
  input  logic [TIME_BITS-1:0]         toggle_ms,
  input  logic [bwi_pkg::CFG_BITS-1:0] interval_ms,
  output logic                         fire
);

  logic [TIME_BITS-1:0] since;

  assign since = now_ms - toggle_ms;
  assign fire = since >= TIME_BITS'(interval_ms);

endmodule

FILE: src/bwi_eval.sv
// Indicator state, per-word evaluation and result register.
module bwi_eval #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             op,
  input  bwi_pkg::item_t   item,
  input  bwi_pkg::cfg_t    cfg,
  output bwi_pkg::result_t res
);

  logic [TIME_BITS-1:0] now_ms, now_ms_next;
  logic [TIME_BITS-1:0] last_message_ms, last_message_ms_next;
  logic [TIME_BITS-1:0] rear_toggle_ms, rear_toggle_ms_next;
  logic [TIME_BITS-1:0] speed_toggle_ms, speed_toggle_ms_next;
  logic [TIME_BITS-1:0] link_since;
  logic rear_blink_on, rear_blink_on_next;
  logic speed_blink_on, speed_blink_on_next;
  logic [bwi_pkg::CODE_BITS-1:0] held_speed_code, held_speed_code_next;
  logic [bwi_pkg::CODE_BITS-1:0] held_rear_code, held_rear_code_next;
  logic [bwi_pkg::COLOR_BITS-1:0] left_px, left_px_next;
  logic [bwi_pkg::COLOR_BITS-1:0] speed_px, speed_px_next;
  logic [bwi_pkg::COLOR_BITS-1:0] rear_px, rear_px_next;
  logic [bwi_pkg::COLOR_BITS-1:0] right_px, right_px_next;

  logic [bwi_pkg::CFG_BITS-1:0] spd_iv, rear_iv;
  logic spd_fire, rear_fire;
  logic sound_valid;
  logic [bwi_pkg::STAGE_BITS-1:0] sound_stage;

  // message latches codes and presence; tick advances time
  always_comb begin
    if (op == bwi_pkg::OP_MESSAGE) begin
      now_ms_next = now_ms;
      last_message_ms_next = now_ms;
      held_speed_code_next = item.speed_code;
      held_rear_code_next = item.rear_code;
      left_px_next = item.left_present ? bwi_pkg::COLOR_GREEN : bwi_pkg::COLOR_OFF;
      right_px_next = item.right_present ? bwi_pkg::COLOR_GREEN : bwi_pkg::COLOR_OFF;
    end else begin
      now_ms_next = now_ms + TIME_BITS'(1);
      last_message_ms_next = last_message_ms;
      held_speed_code_next = held_speed_code;
      held_rear_code_next = held_rear_code;
      left_px_next = left_px;
      right_px_next = right_px;
    end
  end

  always_comb begin
    unique case (held_speed_code_next) inside
      bwi_pkg::SPD_YELLOW_SLOW, bwi_pkg::SPD_RED_SLOW: spd_iv = cfg.slow_blink_ms;
      default: spd_iv = cfg.fast_blink_ms;
    endcase
    unique case (held_rear_code_next)
      bwi_pkg::REAR_YELLOW_SLOW: rear_iv = cfg.slow_blink_ms;
      default: rear_iv = cfg.fast_blink_ms;
    endcase
  end

  bwi_blink #(.TIME_BITS(TIME_BITS)) u_speed_blink (
    .now_ms      (now_ms_next),
    .toggle_ms   (speed_toggle_ms),
    .interval_ms (spd_iv),
    .fire        (spd_fire)
  );

  bwi_blink #(.TIME_BITS(TIME_BITS)) u_rear_blink (
    .now_ms      (now_ms_next),
    .toggle_ms   (rear_toggle_ms),
    .interval_ms (rear_iv),
    .fire        (rear_fire)
  );

  // speed indicator and buzzer
  always_comb begin
    logic                           blink;
    logic [bwi_pkg::COLOR_BITS-1:0] color;
    logic [bwi_pkg::STAGE_BITS-1:0] stage;
    blink = 1'b0;
    color = bwi_pkg::COLOR_OFF;
    stage = bwi_pkg::STAGE_SILENT;
    speed_px_next = speed_px;
    speed_blink_on_next = speed_blink_on;
    speed_toggle_ms_next = speed_toggle_ms;
    sound_valid = 1'b0;
    sound_stage = bwi_pkg::STAGE_SILENT;
    unique case (held_speed_code_next) inside
      bwi_pkg::SPD_OFF: begin
        speed_px_next = bwi_pkg::COLOR_OFF;
        sound_valid = 1'b1;
      end
      bwi_pkg::SPD_YELLOW: begin
        speed_px_next = bwi_pkg::COLOR_YELLOW;
        sound_valid = 1'b1;
      end
      bwi_pkg::SPD_RED: begin
        speed_px_next = bwi_pkg::COLOR_RED;
        sound_valid = 1'b1;
        sound_stage = bwi_pkg::STAGE_2;
      end
      bwi_pkg::SPD_YELLOW_SLOW, bwi_pkg::SPD_YELLOW_FAST: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_YELLOW;
        stage = bwi_pkg::STAGE_1;
      end
      bwi_pkg::SPD_RED_SLOW: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_RED;
        stage = bwi_pkg::STAGE_2;
      end
      bwi_pkg::SPD_RED_FAST: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_RED;
        stage = bwi_pkg::STAGE_3;
      end
      default: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_RED;
        stage = bwi_pkg::STAGE_4;
      end
    endcase
    if (blink && spd_fire) begin
      speed_blink_on_next = !speed_blink_on;
      speed_toggle_ms_next = now_ms_next;
      speed_px_next = speed_blink_on ? bwi_pkg::COLOR_OFF : color;
      sound_valid = 1'b1;
      sound_stage = stage;
    end
  end

  // rear indicator
  always_comb begin
    logic                           blink;
    logic [bwi_pkg::COLOR_BITS-1:0] color;
    blink = 1'b0;
    color = bwi_pkg::COLOR_OFF;
    rear_px_next = rear_px;
    rear_blink_on_next = rear_blink_on;
    rear_toggle_ms_next = rear_toggle_ms;
    unique case (held_rear_code_next) inside
      bwi_pkg::REAR_FAR, bwi_pkg::REAR_MID, bwi_pkg::REAR_NEAR:
        rear_px_next = bwi_pkg::COLOR_GREEN;
      bwi_pkg::REAR_YELLOW: rear_px_next = bwi_pkg::COLOR_YELLOW;
      bwi_pkg::REAR_YELLOW_SLOW, bwi_pkg::REAR_YELLOW_FAST: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_YELLOW;
      end
      bwi_pkg::REAR_RED_FAST: begin
        blink = 1'b1;
        color = bwi_pkg::COLOR_RED;
      end
      default: rear_px_next = bwi_pkg::COLOR_OFF;
    endcase
    if (blink && rear_fire) begin
      rear_blink_on_next = !rear_blink_on;
      rear_toggle_ms_next = now_ms_next;
      rear_px_next = rear_blink_on ? bwi_pkg::COLOR_OFF : color;
    end
  end

  assign link_since = now_ms_next - last_message_ms_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      last_message_ms <= '0;
      rear_toggle_ms <= '0;
      speed_toggle_ms <= '0;
      rear_blink_on <= 1'b0;
      speed_blink_on <= 1'b0;
      held_speed_code <= '0;
      held_rear_code <= '0;
      left_px <= bwi_pkg::COLOR_OFF;
      speed_px <= bwi_pkg::COLOR_OFF;
      rear_px <= bwi_pkg::COLOR_OFF;
      right_px <= bwi_pkg::COLOR_OFF;
    end else if (advance) begin
      now_ms <= now_ms_next;
      last_message_ms <= last_message_ms_next;
      rear_toggle_ms <= rear_toggle_ms_next;
      speed_toggle_ms <= speed_toggle_ms_next;
      rear_blink_on <= rear_blink_on_next;
      speed_blink_on <= speed_blink_on_next;
      held_speed_code <= held_speed_code_next;
      held_rear_code <= held_rear_code_next;
      left_px <= left_px_next;
      speed_px <= speed_px_next;
      rear_px <= rear_px_next;
      right_px <= right_px_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.left_color <= left_px_next;
      res.speed_color <= speed_px_next;
      res.rear_color <= rear_px_next;
      res.right_color <= right_px_next;
      res.sound_valid <= sound_valid;
      res.sound_stage <= sound_stage;
      res.link_lost <= link_since > TIME_BITS'(cfg.link_timeout_ms);
    end
  end

endmodule

FILE: src/blindspot_warning_indicator_unit.sv
// Top level of the blindspot warning indicator: stream ports, config and control.
// Each word on the slave side is a one-millisecond tick (tuser 0) or a sensor message
// (tuser 1) and gives exactly one result word on the master side. A word passes an input
// register, evaluation against the indicator state and the result register; one word
// is taken every cycle while the result side keeps up, the rate being set by the state
// update (time step, blink compares). Blink half periods and link timeout are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while the block is idle
// (the block does not enforce it); indexes 0 fast blink, 1 slow blink, 2 link timeout, others ignored.
module blindspot_warning_indicator_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // speed_code[2:0], rear_code[5:3], left_present[6], right_present[7]
  input  logic [7:0]   s_tdata,
  // op[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // left_color[23:0], speed_color[47:24], rear_color[71:48], right_color[95:72],
  // sound_valid[96], sound_stage[99:97], link_lost[100], zero[103:101]
  output logic [103:0] m_tdata,
  input  logic         cfg_we,
  input  logic [bwi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bwi_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int unsigned RES_BITS = $bits(bwi_pkg::result_t);

  bwi_pkg::cfg_t    cfg;
  bwi_pkg::item_t   in_item;
  bwi_pkg::result_t res;
  logic in_valid;
  logic in_op;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_blink_ms <= bwi_pkg::FAST_BLINK_RESET;
      cfg.slow_blink_ms <= bwi_pkg::SLOW_BLINK_RESET;
      cfg.link_timeout_ms <= bwi_pkg::LINK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bwi_pkg::REG_FAST_BLINK: cfg.fast_blink_ms <= cfg_data;
        bwi_pkg::REG_SLOW_BLINK: cfg.slow_blink_ms <= cfg_data;
        bwi_pkg::REG_LINK_TIMEOUT: cfg.link_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= bwi_pkg::item_t'(s_tdata);
      in_op <= s_tuser;
    end
  end

  bwi_eval #(.TIME_BITS(TIME_BITS)) u_eval (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .op      (in_op),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {(104 - RES_BITS)'(0), res};

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item) && $stable(in_op))
    else $error("input word lost while stalled");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("evaluated word not presented");

  a_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.sound_valid || res.sound_stage == bwi_pkg::STAGE_SILENT))
    else $error("sound stage without sound valid");

  a_msg_link: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == bwi_pkg::OP_MESSAGE |=> !res.link_lost)
    else $error("link lost right after a message");

endmodule

FILE: tb/blindspot_warning_indicator_unit_tb.sv
// Self-checking stream testbench for the blindspot warning indicator unit.
`timescale 1ns / 1ps

module blindspot_warning_indicator_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_WORDS = 1100;
  localparam int PHASE_WORDS = RANDOM_WORDS / 6;
  localparam logic [bwi_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  class indicator_scoreboard;
    logic [bwi_pkg::CFG_BITS-1:0] fast_ms, slow_ms, timeout_ms;
    logic [31:0] now_ms, last_msg_ms, rear_flip_ms, speed_flip_ms;
    logic rear_lit, speed_lit;
    logic [bwi_pkg::CODE_BITS-1:0] speed_code, rear_code;
    logic [bwi_pkg::COLOR_BITS-1:0] left_px, speed_px, rear_px, right_px;
    bwi_pkg::result_t pending_q[$];
    int errors;

    function new();
      fast_ms = bwi_pkg::FAST_BLINK_RESET;
      slow_ms = bwi_pkg::SLOW_BLINK_RESET;
      timeout_ms = bwi_pkg::LINK_TIMEOUT_RESET;
      now_ms = '0;
      last_msg_ms = '0;
      rear_flip_ms = '0;
      speed_flip_ms = '0;
      rear_lit = 1'b0;
      speed_lit = 1'b0;
      speed_code = '0;
      rear_code = '0;
      left_px = bwi_pkg::COLOR_OFF;
      speed_px = bwi_pkg::COLOR_OFF;
      rear_px = bwi_pkg::COLOR_OFF;
      right_px = bwi_pkg::COLOR_OFF;
      errors = 0;
    endfunction

    function void write_reg(logic [bwi_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [bwi_pkg::CFG_BITS-1:0] val);
      case (idx)
        bwi_pkg::REG_FAST_BLINK: fast_ms = val;
        bwi_pkg::REG_SLOW_BLINK: slow_ms = val;
        bwi_pkg::REG_LINK_TIMEOUT: timeout_ms = val;
        default: ;
      endcase
    endfunction

    function bit interval_done(logic [31:0] since, logic [bwi_pkg::CFG_BITS-1:0] ival);
      logic [31:0] gone;
      gone = now_ms - since;
      return gone >= {16'd0, ival};
    endfunction

    function void note_word(logic op, bwi_pkg::item_t it);
      bwi_pkg::result_t r;
      logic steady, issued;
      logic [bwi_pkg::CFG_BITS-1:0] ival;
      logic [bwi_pkg::COLOR_BITS-1:0] hue;
      logic [bwi_pkg::STAGE_BITS-1:0] stage;
      if (op == bwi_pkg::OP_TICK) begin
        now_ms = now_ms + 32'd1;
      end else begin
        speed_code = it.speed_code;
        rear_code = it.rear_code;
        last_msg_ms = now_ms;
        left_px = it.left_present ? bwi_pkg::COLOR_GREEN : bwi_pkg::COLOR_OFF;
        right_px = it.right_present ? bwi_pkg::COLOR_GREEN : bwi_pkg::COLOR_OFF;
      end

      steady = 1'b0;
      ival = fast_ms;
      hue = bwi_pkg::COLOR_RED;
      stage = bwi_pkg::STAGE_SILENT;
      case (speed_code)
        bwi_pkg::SPD_OFF: begin
          steady = 1'b1;
          hue = bwi_pkg::COLOR_OFF;
        end
        bwi_pkg::SPD_YELLOW: begin
          steady = 1'b1;
          hue = bwi_pkg::COLOR_YELLOW;
        end
        bwi_pkg::SPD_YELLOW_SLOW: begin
          ival = slow_ms;
          hue = bwi_pkg::COLOR_YELLOW;
          stage = bwi_pkg::STAGE_1;
        end
        bwi_pkg::SPD_YELLOW_FAST: begin
          hue = bwi_pkg::COLOR_YELLOW;
          stage = bwi_pkg::STAGE_1;
        end
        bwi_pkg::SPD_RED: begin
          steady = 1'b1;
          stage = bwi_pkg::STAGE_2;
        end
        bwi_pkg::SPD_RED_SLOW: begin
          ival = slow_ms;
          stage = bwi_pkg::STAGE_2;
        end
        bwi_pkg::SPD_RED_FAST: stage = bwi_pkg::STAGE_3;
        default: stage = bwi_pkg::STAGE_4;
      endcase
      issued = steady;
      if (steady) begin
        speed_px = hue;
      end else if (interval_done(speed_flip_ms, ival)) begin
        speed_lit = !speed_lit;
        speed_flip_ms = now_ms;
        speed_px = speed_lit ? hue : bwi_pkg::COLOR_OFF;
        issued = 1'b1;
      end

      steady = 1'b0;
      ival = fast_ms;
      hue = bwi_pkg::COLOR_YELLOW;
      case (rear_code) inside
        bwi_pkg::REAR_FAR, bwi_pkg::REAR_MID, bwi_pkg::REAR_NEAR: begin
          steady = 1'b1;
          hue = bwi_pkg::COLOR_GREEN;
        end
        bwi_pkg::REAR_YELLOW_SLOW: ival = slow_ms;
        bwi_pkg::REAR_YELLOW: steady = 1'b1;
        bwi_pkg::REAR_YELLOW_FAST: ;
        bwi_pkg::REAR_RED_FAST: hue = bwi_pkg::COLOR_RED;
        default: begin
          steady = 1'b1;
          hue = bwi_pkg::COLOR_OFF;
        end
      endcase
      if (steady) begin
        rear_px = hue;
      end else if (interval_done(rear_flip_ms, ival)) begin
        rear_lit = !rear_lit;
        rear_flip_ms = now_ms;
        rear_px = rear_lit ? hue : bwi_pkg::COLOR_OFF;
      end

      r.left_color = left_px;
      r.speed_color = speed_px;
      r.rear_color = rear_px;
      r.right_color = right_px;
      r.sound_valid = issued;
      r.sound_stage = issued ? stage : bwi_pkg::STAGE_SILENT;
      r.link_lost = (now_ms - last_msg_ms) > {16'd0, timeout_ms};
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 50) $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [103:0] word);
      bwi_pkg::result_t got, want;
      if (pending_q.size() == 0) begin
        report($sformatf("result word %h with nothing expected", word));
        return;
      end
      want = pending_q.pop_front();
      got = word[100:0];
      if (got.left_color !== want.left_color)
        report($sformatf("left_color %h, want %h", got.left_color, want.left_color));
      if (got.speed_color !== want.speed_color)
        report($sformatf("speed_color %h, want %h", got.speed_color, want.speed_color));
      if (got.rear_color !== want.rear_color)
        report($sformatf("rear_color %h, want %h", got.rear_color, want.rear_color));
      if (got.right_color !== want.right_color)
        report($sformatf("right_color %h, want %h", got.right_color, want.right_color));
      if (got.sound_valid !== want.sound_valid)
        report($sformatf("sound_valid %b, want %b", got.sound_valid, want.sound_valid));
      if (got.sound_stage !== want.sound_stage)
        report($sformatf("sound_stage %0d, want %0d", got.sound_stage, want.sound_stage));
      if (got.link_lost !== want.link_lost)
        report($sformatf("link_lost %b, want %b", got.link_lost, want.link_lost));
      if (word[103:101] !== 3'b000)
        report($sformatf("padding bits %b not zero", word[103:101]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [bwi_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [bwi_pkg::CFG_BITS-1:0] cfg_data = '0;

  int send_idle_pct = 16;
  int recv_idle_pct = 74;
  int random_sent = 0;
  int cycles = 0;
  indicator_scoreboard sb = new();

  blindspot_warning_indicator_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_word(s_tuser, bwi_pkg::item_t'(s_tdata));
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("blindspot_warning_indicator_unit: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic op, input bwi_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [bwi_pkg::CFG_BITS-1:0] fast, slow, timeout);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bwi_pkg::REG_FAST_BLINK;
    cfg_data <= fast;
    @(posedge clk);
    cfg_index <= bwi_pkg::REG_SLOW_BLINK;
    cfg_data <= slow;
    @(posedge clk);
    cfg_index <= bwi_pkg::REG_LINK_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_index <= REG_UNUSED;
    cfg_data <= bwi_pkg::CFG_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // each burst is a message followed by a run of ticks
  task automatic random_phase(input int words, input int pause_at);
    int n, ticks;
    n = 0;
    while (n < words) begin
      ticks = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
      for (int k = 0; k <= ticks && n < words; k++) begin
        if (random_sent < RANDOM_WORDS / 3) begin
          send_idle_pct = 16;
          recv_idle_pct = 74;
        end else if (random_sent < 2 * RANDOM_WORDS / 3) begin
          send_idle_pct = 74;
          recv_idle_pct = 16;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == pause_at) drain();
        send_word((k == 0) ? bwi_pkg::OP_MESSAGE : bwi_pkg::OP_TICK,
                  bwi_pkg::item_t'($urandom_range(255)));
        n++;
        random_sent++;
      end
    end
  endtask

  initial begin
    bwi_pkg::item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(bwi_pkg::OP_TICK, '0);
    send_word(bwi_pkg::OP_MESSAGE, 8'hFF);
    send_word(bwi_pkg::OP_MESSAGE, 8'h00);

    // a zero fast interval blinks on every word, zero timeout trips on any elapsed time
    reconfigure(16'd0, 16'd1, 16'd0);
    send_word(bwi_pkg::OP_TICK, bwi_pkg::item_t'($urandom_range(255)));
    for (int c = 1; c < 8; c++) begin
      it = {c[0], c[1], 3'(c), 3'(c)};
      send_word(bwi_pkg::OP_MESSAGE, it);
      send_word(bwi_pkg::OP_TICK, bwi_pkg::item_t'($urandom_range(255)));
    end

    // blink clock is shared between slow and fast codes
    reconfigure(16'd2, 16'd3, 16'd4);
    it.speed_code = bwi_pkg::SPD_YELLOW_SLOW;
    it.rear_code = bwi_pkg::REAR_YELLOW_SLOW;
    it.left_present = 1'b1;
    it.right_present = 1'b0;
    send_word(bwi_pkg::OP_MESSAGE, it);
    repeat (4) send_word(bwi_pkg::OP_TICK, '0);
    it.speed_code = bwi_pkg::SPD_RED_FAST;
    it.rear_code = bwi_pkg::REAR_RED_FAST;
    it.left_present = 1'b0;
    it.right_present = 1'b1;
    send_word(bwi_pkg::OP_MESSAGE, it);
    repeat (2) send_word(bwi_pkg::OP_TICK, '1);

    reconfigure(16'd2, 16'd5, 16'd8);
    random_phase(PHASE_WORDS, -1);
    reconfigure(16'd1, 16'hFFFF, 16'hFFFF);
    random_phase(PHASE_WORDS, PHASE_WORDS / 2);
    reconfigure(16'hFFFF, 16'd1, 16'd1);
    random_phase(PHASE_WORDS, -1);
    reconfigure(bwi_pkg::CFG_BITS'($urandom_range(1, 8)),
                bwi_pkg::CFG_BITS'($urandom_range(1, 20)),
                bwi_pkg::CFG_BITS'($urandom_range(0, 30)));
    random_phase(PHASE_WORDS, -1);
    reconfigure(bwi_pkg::CFG_BITS'($urandom_range(1, 4)),
                bwi_pkg::CFG_BITS'($urandom_range(1, 6)),
                bwi_pkg::CFG_BITS'($urandom_range(1, 12)));
    random_phase(PHASE_WORDS, -1);
    reconfigure(bwi_pkg::FAST_BLINK_RESET, bwi_pkg::SLOW_BLINK_RESET,
                bwi_pkg::LINK_TIMEOUT_RESET);
    random_phase(RANDOM_WORDS - 5 * PHASE_WORDS, -1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("blindspot_warning_indicator_unit: match");
    end else begin
      $display("blindspot_warning_indicator_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: blindspot_warning_indicator_unit.f
src/bwi_pkg.sv
src/bwi_blink.sv
src/bwi_eval.sv
src/blindspot_warning_indicator_unit.sv
tb/blindspot_warning_indicator_unit_tb.sv
